// File: rtl/core/rals_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rals_pkg: shared types and constants for the row argmin selector
// Field widths, hue range and mode codes used by the interfaces, the
// selector core and its checker.
// ----------------------------------------------------------------------------
package rals_pkg;

   localparam int HUE_W  = 16;
   localparam int LUMA_W = 16;
   localparam int IDX_W  = 12;

   // 360 degrees in 1/128 degree units
   localparam logic [HUE_W-1:0] HUE_FULL = 16'd46080;

   localparam int MAX_ROW_DEFAULT = 4096;

   typedef enum logic {
      MODE_LUMA = 1'b0,
      MODE_HUE  = 1'b1
   } mode_type;

endpackage

// File: rtl/core/rals_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rals_if: pixel and result channels of the row argmin selector
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface rals_req_if import rals_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue;
   logic [LUMA_W-1:0] luma;
   logic              row_end;

   modport source (output valid, output hue, output luma, output row_end, input ready);
   modport sink   (input valid, input hue, input luma, input row_end, output ready);
endinterface

interface rals_rsp_if import rals_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] chosen_index;
   logic             row_too_short;

   modport source (output valid, output chosen_index, output row_too_short, input ready);
   modport sink   (input valid, input chosen_index, input row_too_short, output ready);
endinterface

// File: rtl/core/row_argmin_luma_or_hue_smoothness.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_argmin_luma_or_hue_smoothness: seam carving pixel selector
// Streams the pixels of a row and reports the interior pixel to remove.
// ----------------------------------------------------------------------------
// Takes one pixel per clock, left to right, unless a row end stalls; the
// pixel with row_end set closes the row and yields one transaction on rsp_ch.
// A pixel taken on req_ch is held in the input register and scored from
// there into the row state; a row end writes the result register. The
// sustained rate is one pixel per cycle while no row end waits, as the score
// and running compare are combinational. Interior pixels keep flowing while
// a result waits; only a row end stalls behind an unaccepted result. In mode
// 0 the interior pixel with the least luma wins; in mode 1 the one with the
// least sum of circular hue distances to both neighbours. Ties go left; the
// end pixels are never chosen. A row of fewer than three pixels reports
// index 0 with row_too_short set. Positions past MAX_ROW-1 saturate. Write
// select_mode through csr_we/csr_wdata only while no row is in progress.
module row_argmin_luma_or_hue_smoothness
   import rals_pkg::*;
#(
   parameter int MAX_ROW = MAX_ROW_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   rals_req_if.sink   req_ch,
   rals_rsp_if.source rsp_ch,
   input  logic       csr_we,
   input  logic       csr_wdata
);

   localparam int               PosW    = $clog2(MAX_ROW);
   localparam logic [PosW-1:0]  PosLast = PosW'(MAX_ROW - 1);
   localparam logic [PosW-1:0]  PosTwo  = PosW'(2);
   localparam logic [PosW-1:0]  PosOne  = PosW'(1);

   function automatic logic [HUE_W-1:0] hue_dist(input logic [HUE_W-1:0] a,
                                                 input logic [HUE_W-1:0] b);
      logic [HUE_W-1:0] d;
      logic [HUE_W-1:0] around;
      d      = (a > b) ? a - b : b - a;
      around = HUE_FULL - d;
      return (around < d) ? around : d;
   endfunction

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic [HUE_W-1:0]  s1_hue_ff;
   logic [LUMA_W-1:0] s1_luma_ff;
   logic              s1_end_ff;

   // row state
   mode_type          mode_ff;
   logic [PosW-1:0]   pos_ff, pos_in;
   logic [HUE_W-1:0]  hue_prev_ff, hue_prev_in;
   logic [LUMA_W-1:0] luma_prev_ff, luma_prev_in;
   logic [HUE_W-1:0]  dist_prev_ff, dist_prev_in;
   logic [15:0]       best_score_ff, best_score_in;
   logic [PosW-1:0]   best_pos_ff, best_pos_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic              rsp_short_ff, rsp_short_in;

   logic              out_free;
   logic              s1_fire;
   logic              s1_take;
   logic [HUE_W-1:0]  hue_wrap;
   logic [HUE_W-1:0]  dist_cur;
   logic [HUE_W:0]    hue_sum;
   logic [15:0]       score;
   logic              cand;
   logic              take_best;
   logic [PosW-1:0]   best_pos_new;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   // only a row end needs room in the result register
   assign s1_fire  = s1_valid_ff && (!s1_end_ff || out_free);
   assign s1_take  = !s1_valid_ff || s1_fire;

   assign req_ch.ready          = s1_take;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.chosen_index   = rsp_index_ff;
   assign rsp_ch.row_too_short  = rsp_short_ff;

   always_comb begin
      hue_wrap  = (s1_hue_ff >= HUE_FULL) ? s1_hue_ff - HUE_FULL : s1_hue_ff;
      dist_cur  = hue_dist(hue_prev_ff, hue_wrap);
      hue_sum   = {1'b0, dist_prev_ff} + {1'b0, dist_cur};
      score     = (mode_ff == MODE_LUMA) ? luma_prev_ff : hue_sum[15:0];
      cand      = (pos_ff >= PosTwo);
      take_best = cand && ((best_pos_ff == '0) || (score < best_score_ff));
      best_pos_new = take_best ? pos_ff - PosOne : best_pos_ff;
   end

   always_comb begin
      s1_valid_in   = s1_take ? req_ch.valid : s1_valid_ff;
      pos_in        = pos_ff;
      hue_prev_in   = hue_prev_ff;
      luma_prev_in  = luma_prev_ff;
      dist_prev_in  = dist_prev_ff;
      best_score_in = best_score_ff;
      best_pos_in   = best_pos_ff;
      rsp_valid_in  = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_short_in  = rsp_short_ff;
      if (s1_fire) begin
         if (s1_end_ff) begin
            // close the row and clear its history
            rsp_valid_in  = 1'b1;
            rsp_short_in  = !cand;
            rsp_index_in  = cand ? IDX_W'(best_pos_new) : '0;
            pos_in        = '0;
            hue_prev_in   = '0;
            luma_prev_in  = '0;
            dist_prev_in  = '0;
            best_score_in = '1;
            best_pos_in   = '0;
         end else begin
            if (take_best) begin
               best_score_in = score;
               best_pos_in   = best_pos_new;
            end
            hue_prev_in  = hue_wrap;
            luma_prev_in = s1_luma_ff;
            dist_prev_in = dist_cur;
            if (pos_ff < PosLast) begin
               pos_in = pos_ff + PosOne;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         mode_ff       <= MODE_LUMA;
         pos_ff        <= '0;
         hue_prev_ff   <= '0;
         luma_prev_ff  <= '0;
         dist_prev_ff  <= '0;
         best_score_ff <= '1;
         best_pos_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         if (csr_we) begin
            mode_ff <= mode_type'(csr_wdata);
         end
         pos_ff        <= pos_in;
         hue_prev_ff   <= hue_prev_in;
         luma_prev_ff  <= luma_prev_in;
         dist_prev_ff  <= dist_prev_in;
         best_score_ff <= best_score_in;
         best_pos_ff   <= best_pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_hue_ff  <= req_ch.hue;
         s1_luma_ff <= req_ch.luma;
         s1_end_ff  <= req_ch.row_end;
      end
      rsp_index_ff <= rsp_index_in;
      rsp_short_ff <= rsp_short_in;
   end

endmodule

// File: rtl/core/rals_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rals_checker: port-level checks for the row argmin selector
// Watches the result channel and flags malformed or unstable transactions.
// ----------------------------------------------------------------------------
module rals_checker
   import rals_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [IDX_W-1:0] rsp_chosen_index,
   input logic             rsp_row_too_short
);

   // a stalled result must hold
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_chosen_index)
                                  && $stable(rsp_row_too_short))
      else $error("result changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_too_short |-> rsp_chosen_index == '0)
      else $error("short row reports a nonzero index");

   // an end pixel is never chosen, so a full row never reports index 0
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_row_too_short |-> rsp_chosen_index != '0)
      else $error("full row reports index 0");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind row_argmin_luma_or_hue_smoothness rals_checker u_rals_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_chosen_index  (rsp_ch.chosen_index),
   .rsp_row_too_short (rsp_ch.row_too_short)
);
